// ===== hdl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the shrinking-core rate unit
// Fixed-point constants, configuration register codes, the sideband that
// travels with every request, and the stage counts of each pipeline section.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Q16.16 one, unit-fraction limits and output saturation levels
  localparam logic [16:0] ONE     = 17'h1_0000;
  localparam logic [30:0] X_MAX   = 31'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;
  localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;

  // pipeline depth of each section, from input to registered output
  localparam int FRAC_LAT = 34;
  localparam int CBRT_LAT = 21;
  localparam int TERM_LAT = 3;
  localparam int QUOT_LAT = 94;
  localparam int MIX_LAT  = 4;
  localparam int LATENCY  = FRAC_LAT + CBRT_LAT + TERM_LAT + QUOT_LAT + MIX_LAT;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_FILM     = 2'd1,
    REG_PORE     = 2'd2,
    REG_REACTION = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] capacity;
    logic [30:0] film;
    logic [30:0] pore;
    logic [30:0] reaction;
  } cfg_t;

  // request fields that ride along to the final products
  typedef struct packed {
    logic signed [31:0] qdot;
    logic signed [31:0] test;
    logic signed [31:0] shape;
    logic signed [31:0] rfac;
  } side_t;

endpackage

// ===== hdl/scr_frac.sv =====
// ----------------------------------------------------------------------------
// scr_frac: unreacted fraction
// Restoring divider, one quotient bit per stage, forming 1 - q/capacity.
// ----------------------------------------------------------------------------
module scr_frac (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [31:0]  amount,
  input  scr_pkg::side_t      in_side,
  input  logic [30:0]         capacity,
  output logic                out_vld,
  output logic [30:0]         frac,
  output logic                out_zero,
  output scr_pkg::side_t      out_side
);

  localparam int STEPS = 32;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic           czero;
    logic [31:0]    rem;
    logic [31:0]    sh;    // dividend bits leave at the top, quotient enters below
    scr_pkg::side_t side;
  } fdiv_t;

  fdiv_t       st  [0:STEPS];
  logic        vld [0:STEPS];
  logic [31:0] mag;
  logic [31:0] quot;
  logic [32:0] sum;

  assign mag = amount[31] ? 32'(-amount) : 32'(amount);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    st[0].neg   <= amount[31];
    st[0].ovf   <= {15'b0, mag[31:16]} >= capacity;
    st[0].czero <= capacity == '0;
    st[0].rem   <= {16'b0, mag[31:16]};
    st[0].sh    <= {mag[15:0], 16'b0};
    st[0].side  <= in_side;
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    fdiv_t       nxt;

    assign trial = {st[k-1].rem, st[k-1].sh[31]};
    assign ge    = trial >= {2'b0, capacity};

    always_comb begin
      nxt     = st[k-1];
      nxt.rem = ge ? 32'(trial - {2'b0, capacity}) : trial[31:0];
      nxt.sh  = {st[k-1].sh[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      st[k] <= nxt;
    end
  end

  assign quot = st[STEPS].sh;
  assign sum  = {1'b0, quot} + 33'(scr_pkg::ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[STEPS];
    end
    out_side <= st[STEPS].side;
    if (st[STEPS].neg) begin
      out_zero <= st[STEPS].czero;
      frac     <= (st[STEPS].ovf || sum > 33'(scr_pkg::X_MAX)) ? scr_pkg::X_MAX : sum[30:0];
    end else begin
      out_zero <= st[STEPS].czero || st[STEPS].ovf || quot >= 32'(scr_pkg::ONE);
      frac     <= 31'(33'(scr_pkg::ONE) - {1'b0, quot});
    end
  end

endmodule

// ===== hdl/scr_cbrt.sv =====
// ----------------------------------------------------------------------------
// scr_cbrt: cube root
// Digit-by-digit integer cube root of frac * 2^32, three radicand bits per
// stage; the root squared is kept alongside, so no multiplier is needed.
// ----------------------------------------------------------------------------
module scr_cbrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [30:0]     in_frac,
  input  logic            in_zero,
  input  scr_pkg::side_t  in_side,
  output logic            out_vld,
  output logic [20:0]     root1,
  output logic [25:0]     root2,
  output logic [30:0]     out_frac,
  output logic            out_zero,
  output scr_pkg::side_t  out_side
);

  localparam int STEPS = 21;

  typedef struct packed {
    logic [62:0]    rem;
    logic [20:0]    root;
    logic [41:0]    sq;
    logic [30:0]    frac;
    logic           zero;
    scr_pkg::side_t side;
  } cbrt_t;

  cbrt_t st  [0:STEPS-1];
  logic  vld [0:STEPS-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SHIFT = 3 * (STEPS - 1 - k);
    cbrt_t       prev;
    cbrt_t       nxt;
    logic        pvld;
    logic [20:0] dbl;
    logic [41:0] sq4;
    logic [43:0] base;
    logic [43:0] term;
    logic [62:0] top;
    logic        take;

    if (k == 0) begin : g_first
      assign prev = '{rem: {in_frac, 32'b0}, root: '0, sq: '0, frac: in_frac,
                      zero: in_zero, side: in_side};
      assign pvld = in_vld;
    end else begin : g_next
      assign prev = st[k-1];
      assign pvld = vld[k-1];
    end

    assign dbl  = {prev.root[19:0], 1'b0};
    assign sq4  = {prev.sq[39:0], 2'b0};
    assign base = 44'(sq4) + 44'(dbl);
    assign term = {base[42:0], 1'b0} + base + 44'd1;
    assign top  = prev.rem >> SHIFT;
    assign take = top >= 63'(term);

    always_comb begin
      nxt      = prev;
      nxt.rem  = take ? prev.rem - (63'(term) << SHIFT) : prev.rem;
      nxt.root = take ? dbl + 21'd1 : dbl;
      nxt.sq   = take ? sq4 + 42'({dbl, 1'b0}) + 42'd1 : sq4;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pvld;
      end
      st[k] <= nxt;
    end
  end

  assign out_vld  = vld[STEPS-1];
  assign root1    = st[STEPS-1].root;
  assign root2    = st[STEPS-1].sq[41:16];
  assign out_frac = st[STEPS-1].frac;
  assign out_zero = st[STEPS-1].zero;
  assign out_side = st[STEPS-1].side;

endmodule

// ===== hdl/scr_terms.sv =====
// ----------------------------------------------------------------------------
// scr_terms: rate terms
// Products of the time constants with the fraction and its roots, then the
// denominator h, numerator g and derivative numerator n.
// ----------------------------------------------------------------------------
module scr_terms (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [30:0]     frac,
  input  logic [20:0]     root1,
  input  logic [25:0]     root2,
  input  logic            in_zero,
  input  scr_pkg::side_t  in_side,
  input  scr_pkg::cfg_t   cfg,
  output logic            out_vld,
  output logic [47:0]     gnum,
  output logic [43:0]     nnum,
  output logic [52:0]     hmag,
  output logic            hneg,
  output logic            out_zero,
  output scr_pkg::side_t  out_side
);

  logic signed [33:0] dt;
  logic signed [31:0] xs;
  logic signed [52:0] ae;
  logic signed [52:0] be;
  logic signed [52:0] ce;

  // stage 1: products
  logic               v1;
  logic [56:0]        p1;
  logic [51:0]        p2;
  logic signed [65:0] p3;
  logic [61:0]        p4;
  logic               z1;
  scr_pkg::side_t     s1;

  // stage 2: sums
  logic               v2;
  logic signed [52:0] h2;
  logic [47:0]        g2;
  logic [43:0]        n2;
  logic               z2;
  scr_pkg::side_t     s2;

  assign dt = $signed({3'b0, cfg.film}) - $signed({2'b0, cfg.pore, 1'b0});
  assign xs = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_vld;
    end
    p1 <= 57'(cfg.pore) * 57'(root2);
    p2 <= 52'(cfg.reaction) * 52'(root1);
    p3 <= dt * xs;
    p4 <= 62'(cfg.capacity) * 62'(frac);
    z1 <= in_zero;
    s1 <= in_side;
  end

  // keep the sign of the film term through the shift
  assign ae = 53'($signed(p3[65:16]));
  assign be = $signed({12'b0, p1[56:16]});
  assign ce = $signed({17'b0, p2[51:16]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    h2 <= (ae <<< 1) + ae + (be <<< 2) + (be <<< 1) + ce;
    g2 <= {p4[61:16], 1'b0} + 48'(p4[61:16]);
    n2 <= {p1[56:16], 2'b0} + {1'b0, p1[56:16], 1'b0} + {7'b0, p2[51:16], 1'b0};
    z2 <= z1;
    s2 <= s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= v2;
    end
    hmag     <= h2[52] ? 53'(-h2) : 53'(h2);
    hneg     <= h2[52];
    gnum     <= g2;
    nnum     <= n2;
    out_zero <= z2;
    out_side <= s2;
  end

endmodule

// ===== hdl/scr_quot.sv =====
// ----------------------------------------------------------------------------
// scr_quot: rate and derivative quotients
// Sixty restoring steps for n/|h|, then thirty-two paired steps for g/|h|
// and for n/|h| over |h| again, with capping at the output.
// ----------------------------------------------------------------------------
module scr_quot (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [47:0]         gnum,
  input  logic [43:0]         nnum,
  input  logic [52:0]         hmag,
  input  logic                hneg,
  input  logic                in_zero,
  input  scr_pkg::side_t      in_side,
  output logic                out_vld,
  output logic signed [31:0]  rate,
  output logic [31:0]         dmag,
  output scr_pkg::side_t      out_side
);

  localparam int INNER = 60;
  localparam int OUTER = 32;

  typedef struct packed {
    logic [52:0]    rem;
    logic [59:0]    sh;
    logic [47:0]    g;
    logic [52:0]    hm;
    logic           hneg;
    logic           nz;
    logic           zero;
    scr_pkg::side_t side;
  } inner_t;

  typedef struct packed {
    logic [52:0]    rrem;
    logic [31:0]    rsh;
    logic           rovf;
    logic           gz;
    logic [52:0]    drem;
    logic [31:0]    dsh;
    logic           dovf;
    logic           hz;
    logic           nz;
    logic [52:0]    hm;
    logic           hneg;
    logic           zero;
    scr_pkg::side_t side;
  } outer_t;

  inner_t ist  [0:INNER-1];
  logic   ivld [0:INNER-1];
  outer_t ost  [0:OUTER];
  logic   ovld [0:OUTER];

  logic [59:0] iq;
  logic [31:0] rq;
  logic [31:0] dq;
  logic [31:0] rm;

  // one restoring step: {next remainder, next shift word}
  function automatic logic [84:0] div_step(input logic [52:0] rem, input logic [31:0] sh,
                                           input logic [52:0] den);
    logic [53:0] trial;
    logic        ge;
    trial = {rem, sh[31]};
    ge    = trial >= {1'b0, den};
    return {ge ? 53'(trial - {1'b0, den}) : trial[52:0], sh[30:0], ge};
  endfunction

  for (genvar k = 0; k < INNER; k++) begin : g_inner
    inner_t      prev;
    inner_t      nxt;
    logic        pvld;
    logic [53:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign prev = '{rem: '0, sh: {nnum, 16'b0}, g: gnum, hm: hmag, hneg: hneg,
                      nz: nnum != '0, zero: in_zero, side: in_side};
      assign pvld = in_vld;
    end else begin : g_next
      assign prev = ist[k-1];
      assign pvld = ivld[k-1];
    end

    assign trial = {prev.rem, prev.sh[59]};
    assign ge    = trial >= {1'b0, prev.hm};

    always_comb begin
      nxt     = prev;
      nxt.rem = ge ? 53'(trial - {1'b0, prev.hm}) : trial[52:0];
      nxt.sh  = {prev.sh[58:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ivld[k] <= 1'b0;
      end else begin
        ivld[k] <= pvld;
      end
      ist[k] <= nxt;
    end
  end

  assign iq = ist[INNER-1].sh;

  // set up both quotients that share the second pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ovld[0] <= 1'b0;
    end else begin
      ovld[0] <= ivld[INNER-1];
    end
    ost[0].rrem <= 53'(ist[INNER-1].g[47:16]);
    ost[0].rsh  <= {ist[INNER-1].g[15:0], 16'b0};
    ost[0].rovf <= 53'(ist[INNER-1].g[47:16]) >= ist[INNER-1].hm;
    ost[0].gz   <= ist[INNER-1].g == '0;
    ost[0].drem <= 53'(iq[59:16]);
    ost[0].dsh  <= {iq[15:0], 16'b0};
    ost[0].dovf <= 53'(iq[59:16]) >= ist[INNER-1].hm;
    ost[0].hz   <= ist[INNER-1].hm == '0;
    ost[0].nz   <= ist[INNER-1].nz;
    ost[0].hm   <= ist[INNER-1].hm;
    ost[0].hneg <= ist[INNER-1].hneg;
    ost[0].zero <= ist[INNER-1].zero;
    ost[0].side <= ist[INNER-1].side;
  end

  for (genvar k = 1; k <= OUTER; k++) begin : g_outer
    logic [84:0] rnext;
    logic [84:0] dnext;
    outer_t      nxt;

    assign rnext = div_step(ost[k-1].rrem, ost[k-1].rsh, ost[k-1].hm);
    assign dnext = div_step(ost[k-1].drem, ost[k-1].dsh, ost[k-1].hm);

    always_comb begin
      nxt      = ost[k-1];
      nxt.rrem = rnext[84:32];
      nxt.rsh  = rnext[31:0];
      nxt.drem = dnext[84:32];
      nxt.dsh  = dnext[31:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ovld[k] <= 1'b0;
      end else begin
        ovld[k] <= ovld[k-1];
      end
      ost[k] <= nxt;
    end
  end

  assign rq = ost[OUTER].rsh;
  assign dq = ost[OUTER].dsh;
  assign rm = ost[OUTER].gz ? '0 :
              (ost[OUTER].rovf || rq[31]) ? scr_pkg::NEG_LIM : rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= ovld[OUTER];
    end
    out_side <= ost[OUTER].side;
    if (ost[OUTER].zero) begin
      rate <= '0;
      dmag <= '0;
    end else begin
      if (ost[OUTER].hneg) begin
        rate <= $signed(-rm);
      end else begin
        rate <= $signed(rm[31] ? scr_pkg::POS_LIM : rm);
      end
      if (ost[OUTER].hz) begin
        dmag <= ost[OUTER].nz ? scr_pkg::NEG_LIM : '0;
      end else begin
        dmag <= (ost[OUTER].dovf || dq[31]) ? scr_pkg::NEG_LIM : dq;
      end
    end
  end

endmodule

// ===== hdl/scr_mix.sv =====
// ----------------------------------------------------------------------------
// scr_mix: residual and Jacobian
// Saturating Q16.16 products of the test and shape values with the rate
// differences; the wide Jacobian product is split into two partials.
// ----------------------------------------------------------------------------
module scr_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [31:0]  rate,
  input  logic [31:0]         dmag,
  input  scr_pkg::side_t      in_side,
  output logic                done,
  output logic signed [31:0]  residual,
  output logic signed [31:0]  jacobian,
  output logic signed [31:0]  core_rate
);

  // stage 1
  logic               v1;
  logic signed [32:0] a1;
  logic signed [32:0] e1;
  logic signed [31:0] r1;
  scr_pkg::side_t     s1;

  // stage 2
  logic               v2;
  logic [64:0]        mr;
  logic               rneg;
  logic [63:0]        mt;
  logic [32:0]        em;
  logic               jneg2;
  logic signed [31:0] r2;

  // stage 3
  logic               v3;
  logic signed [31:0] res3;
  logic [56:0]        plo;
  logic [55:0]        phi;
  logic               jneg3;
  logic signed [31:0] r3;

  logic [31:0] tmag;
  logic [32:0] amag;
  logic [31:0] smag;
  logic [47:0] tsm;
  logic [79:0] jsum;

  function automatic logic [31:0] sat_q(input logic [63:0] m, input logic neg);
    logic big;
    big = m[63:31] != '0;
    if (neg) begin
      return big ? scr_pkg::NEG_LIM : 32'(-m[31:0]);
    end
    return big ? scr_pkg::POS_LIM : m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_vld;
    end
    a1 <= 33'(in_side.qdot) - 33'(rate);
    e1 <= 33'(in_side.rfac) + $signed({1'b0, dmag});
    r1 <= rate;
    s1 <= in_side;
  end

  assign tmag = s1.test[31] ? 32'(-s1.test) : 32'(s1.test);
  assign smag = s1.shape[31] ? 32'(-s1.shape) : 32'(s1.shape);
  assign amag = a1[32] ? 33'(-a1) : 33'(a1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    mr    <= 65'(tmag) * 65'(amag);
    rneg  <= s1.test[31] != a1[32];
    mt    <= 64'(tmag) * 64'(smag);
    em    <= e1[32] ? 33'(-e1) : 33'(e1);
    jneg2 <= (s1.test[31] != s1.shape[31]) != e1[32];
    r2    <= r1;
  end

  assign tsm = mt[63:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    res3  <= $signed(sat_q(64'(mr[64:16]), rneg));
    plo   <= 57'(tsm[23:0]) * 57'(em);
    phi   <= 56'(tsm[46:24]) * 56'(em);
    jneg3 <= jneg2;
    r3    <= r2;
  end

  assign jsum = {phi, 24'b0} + 80'(plo);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    residual  <= res3;
    jacobian  <= $signed(sat_q(jsum[79:16], jneg3));
    core_rate <= r3;
  end

endmodule

// ===== hdl/shrinking_core_rate_residual_unit.sv =====
// ----------------------------------------------------------------------------
// shrinking_core_rate_residual_unit: shrinking-core rate residual, top level
// Takes one quadrature-point request per cycle and returns the residual, the
// Jacobian entry and the shrinking-core rate in signed Q16.16.
// ----------------------------------------------------------------------------
// A request is taken at any clock edge with start high; busy is always low,
// so a new request may follow every cycle. Each request returns exactly one
// result, flagged by done for a single cycle, in request order; the receiver
// cannot stall and must take it then. The path is a chain of registered
// stages: 34 for the unreacted fraction divider, 21 for the cube root, 3 for
// the rate terms, 94 for the two chained quotients over |h| and 4 for the
// output products. Write the configuration registers (capacity, film, pore
// and reaction time, each 31-bit unsigned Q16.16, reset to 1.0) only while
// no request is in flight.
// ----------------------------------------------------------------------------
module shrinking_core_rate_residual_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_wr,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic signed [31:0]  adsorbed_amount,
  input  logic signed [31:0]  amount_rate,
  input  logic signed [31:0]  test_value,
  input  logic signed [31:0]  shape_value,
  input  logic signed [31:0]  rate_factor,
  output logic                done,
  output logic signed [31:0]  residual,
  output logic signed [31:0]  jacobian,
  output logic signed [31:0]  core_rate
);

  scr_pkg::cfg_t  cfg;
  scr_pkg::side_t in_side;

  // fraction section outputs
  logic           f_vld;
  logic [30:0]    f_frac;
  logic           f_zero;
  scr_pkg::side_t f_side;

  // cube root section outputs
  logic           c_vld;
  logic [20:0]    c_root1;
  logic [25:0]    c_root2;
  logic [30:0]    c_frac;
  logic           c_zero;
  scr_pkg::side_t c_side;

  // rate term outputs
  logic           t_vld;
  logic [47:0]    t_g;
  logic [43:0]    t_n;
  logic [52:0]    t_hm;
  logic           t_hneg;
  logic           t_zero;
  scr_pkg::side_t t_side;

  // quotient outputs
  logic               q_vld;
  logic signed [31:0] q_rate;
  logic [31:0]        q_dmag;
  scr_pkg::side_t     q_side;

  // the pipeline never holds off a request
  assign busy = 1'b0;

  // configuration registers; hold between writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= 31'(scr_pkg::ONE);
      cfg.film     <= 31'(scr_pkg::ONE);
      cfg.pore     <= 31'(scr_pkg::ONE);
      cfg.reaction <= 31'(scr_pkg::ONE);
    end else if (cfg_wr) begin
      case (scr_pkg::reg_idx_t'(cfg_index))
        scr_pkg::REG_CAPACITY: cfg.capacity <= cfg_data;
        scr_pkg::REG_FILM:     cfg.film     <= cfg_data;
        scr_pkg::REG_PORE:     cfg.pore     <= cfg_data;
        scr_pkg::REG_REACTION: cfg.reaction <= cfg_data;
        default: ;
      endcase
    end
  end

  // fields used only by the final products travel as one sideband
  assign in_side = '{qdot: amount_rate, test: test_value, shape: shape_value,
                     rfac: rate_factor};

  // X = 1 - q/capacity, with depletion and zero capacity flagged
  scr_frac u_frac (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start),
    .amount   (adsorbed_amount),
    .in_side  (in_side),
    .capacity (cfg.capacity),
    .out_vld  (f_vld),
    .frac     (f_frac),
    .out_zero (f_zero),
    .out_side (f_side)
  );

  // X^(1/3) and X^(2/3)
  scr_cbrt u_cbrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_frac  (f_frac),
    .in_zero  (f_zero),
    .in_side  (f_side),
    .out_vld  (c_vld),
    .root1    (c_root1),
    .root2    (c_root2),
    .out_frac (c_frac),
    .out_zero (c_zero),
    .out_side (c_side)
  );

  // h, g and n from the time constants
  scr_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (c_vld),
    .frac     (c_frac),
    .root1    (c_root1),
    .root2    (c_root2),
    .in_zero  (c_zero),
    .in_side  (c_side),
    .cfg      (cfg),
    .out_vld  (t_vld),
    .gnum     (t_g),
    .nnum     (t_n),
    .hmag     (t_hm),
    .hneg     (t_hneg),
    .out_zero (t_zero),
    .out_side (t_side)
  );

  // rate = g/h, derivative magnitude = (n/|h|)/|h|
  scr_quot u_quot (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (t_vld),
    .gnum     (t_g),
    .nnum     (t_n),
    .hmag     (t_hm),
    .hneg     (t_hneg),
    .in_zero  (t_zero),
    .in_side  (t_side),
    .out_vld  (q_vld),
    .rate     (q_rate),
    .dmag     (q_dmag),
    .out_side (q_side)
  );

  // residual and Jacobian, registered straight onto the result ports
  scr_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (q_vld),
    .rate      (q_rate),
    .dmag      (q_dmag),
    .in_side   (q_side),
    .done      (done),
    .residual  (residual),
    .jacobian  (jacobian),
    .core_rate (core_rate)
  );

endmodule

// ===== hdl/scr_check.sv =====
// ----------------------------------------------------------------------------
// scr_check: port-level checks of the shrinking-core rate unit
// Fixed latency, zero test value and reset behavior as seen on the ports.
// ----------------------------------------------------------------------------
module scr_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] test_value,
  input logic signed [31:0] residual,
  input logic signed [31:0] jacobian
);

  // every result answers a request taken a fixed number of cycles earlier
  a_latency: assert property (@(posedge clk)
    done |-> $past(start && !busy, scr_pkg::LATENCY))
    else $error("result without a matching request");

  // a zero test value gives a zero residual and Jacobian
  a_zero_test: assert property (@(posedge clk) disable iff (rst)
    (done && $past(test_value, scr_pkg::LATENCY) == '0) |-> (residual == '0 && jacobian == '0))
    else $error("nonzero result for zero test value");

  // reset drops everything in flight
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind shrinking_core_rate_residual_unit scr_check u_check (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shrinking-core rate residual unit
// Drives quadrature-point requests with random gaps under several register
// settings. A bit-exact fixed-point predictor works out the residual,
// Jacobian entry and core rate of each request. Each result is checked in
// order against the oldest one waiting.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] residual;
    logic signed [31:0] jacobian;
    logic signed [31:0] core_rate;
  } point_result_t;

  // Bit-exact rate predictor plus the queue of results still owed by the unit
  class rate_scoreboard;
    longint capacity, film, pore, reaction;
    point_result_t owed[$];
    int mismatches;

    function new();
      capacity = 65536; film = 65536; pore = 65536; reaction = 65536;
      mismatches = 0;
    endfunction

    function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(0) - v : v;
    endfunction

    // floor(num * ONE / den), clipped at lim
    function automatic longint unsigned scaled_quot(longint unsigned num,
        longint unsigned den, longint unsigned lim);
      logic [127:0] w;
      if (den == 0) return (num != 0) ? lim : 0;
      w = ({64'd0, num} << 16) / {64'd0, den};
      return (w > {64'd0, lim}) ? lim : w[63:0];
    endfunction

    // trunc(a * b / ONE) saturated to [-lim, lim-1]
    function automatic longint fixed_prod(longint a, longint b, longint unsigned lim);
      logic [127:0] p;
      longint unsigned m;
      bit neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      m = (p[127:80] != 0) ? lim : p[79:16];
      if (neg) return (m >= lim) ? -longint'(lim) : -longint'(m);
      return (m >= lim) ? longint'(lim - 1) : longint'(m);
    endfunction

    // floor(cbrt(x * 2^32)), bit by bit from the top
    function automatic longint unsigned cube_root(longint unsigned x);
      logic [127:0] cw;
      longint unsigned y, c, tgt;
      y = 0;
      tgt = x << 32;
      for (int b = 30; b >= 0; b--) begin
        c = y | (64'd1 << b);
        cw = {64'd0, c};
        if (cw * cw * cw <= {64'd0, tgt}) y = c;
      end
      return y;
    endfunction

    // note an accepted request and queue the result it must produce
    function void note_request(logic signed [31:0] q, logic signed [31:0] qdot,
        logic signed [31:0] test, logic signed [31:0] shape, logic signed [31:0] rfac);
      longint x, c1, c2, h, g, n, t2c2, t3c1, rate, deriv, ts;
      longint unsigned hm, m;
      point_result_t e;
      rate = 0;
      deriv = 0;
      if (capacity > 0) begin
        x = 65536 - (longint'(q) * 65536) / capacity;
        if (x > 0) begin
          if (x > 64'h7FFF_FFFF) x = 64'h7FFF_FFFF;
          c1 = cube_root(x);
          c2 = (c1 * c1) >>> 16;
          t2c2 = (pore * c2) >>> 16;
          t3c1 = (reaction * c1) >>> 16;
          h = 3 * (((film - 2 * pore) * x) >>> 16) + 6 * t2c2 + t3c1;
          g = 3 * ((capacity * x) >>> 16);
          n = 6 * t2c2 + 2 * t3c1;
          hm = mag(h);
          m = scaled_quot(g, hm, 64'h8000_0000);
          if (h >= 0) rate = (m >= 64'h8000_0000) ? 64'h7FFF_FFFF : m;
          else rate = -longint'(m);
          m = scaled_quot(scaled_quot(n, hm, 64'd1 << 62), hm, 64'h8000_0000);
          deriv = -longint'(m);
        end
      end
      ts = fixed_prod(test, shape, 64'd1 << 62);
      e.residual = 32'(fixed_prod(test, longint'(qdot) - rate, 64'h8000_0000));
      e.jacobian = 32'(fixed_prod(ts, longint'(rfac) - deriv, 64'h8000_0000));
      e.core_rate = 32'(rate);
      owed.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] res, logic signed [31:0] jac,
        logic signed [31:0] rate);
      point_result_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d", res, jac, rate);
        return;
      end
      e = owed.pop_front();
      if (res !== e.residual || jac !== e.jacobian || rate !== e.core_rate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp res=%0d jac=%0d rate=%0d got res=%0d jac=%0d rate=%0d",
                   e.residual, e.jacobian, e.core_rate, res, jac, rate);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_wr = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic signed [31:0] adsorbed_amount = '0, amount_rate = '0, test_value = '0;
  logic signed [31:0] shape_value = '0, rate_factor = '0;
  logic done;
  logic signed [31:0] residual, jacobian, core_rate;

  rate_scoreboard sb = new();
  int accepted = 0;
  int quiet_cycles = 0;

  shrinking_core_rate_residual_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take requests and results at the rising edge; the watchdog counts edges
  // at which neither moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(adsorbed_amount, amount_rate, test_value, shape_value, rate_factor);
        accepted <= accepted + 1;
      end
      if (done) sb.check_result(residual, jacobian, core_rate);
      quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // mostly short gaps, now and then a long one, often none at all
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // field value: corner, small Q16.16 or full-range
  function automatic logic [31:0] field_value();
    logic [31:0] corners[7];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'hFFFF_FFFF, 32'h0001_0000,
                32'hFFFF_0000};
    case ($urandom_range(0, 7))
      0: return corners[$urandom_range(0, 6)];
      1, 2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // Hold the request until it is taken; drop start afterward only if a gap follows.
  task automatic send_request(logic [31:0] q, logic [31:0] qdot, logic [31:0] test,
      logic [31:0] shape, logic [31:0] rfac);
    int seen, gap;
    seen = accepted;
    adsorbed_amount = q;
    amount_rate = qdot;
    test_value = test;
    shape_value = shape;
    rate_factor = rfac;
    start = 1'b1;
    while (accepted == seen) @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // amount near the capacity so the fraction spans depleted to full
  task automatic send_random();
    logic [31:0] q;
    int unsigned cap;
    cap = 32'(sb.capacity);
    case ($urandom_range(0, 3))
      0: q = field_value();
      1: q = $urandom_range(0, cap);
      2: q = cap + $urandom_range(0, 3) - 1;
      default: q = -$urandom_range(0, cap);
    endcase
    send_request(q, field_value(), field_value(), field_value(), field_value());
  endtask

  // Drain every outstanding request, then write one register while idle.
  task automatic write_reg(scr_pkg::reg_idx_t idx, logic [30:0] value);
    start = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_wr = 1'b0;
    case (idx)
      scr_pkg::REG_CAPACITY: sb.capacity = value;
      scr_pkg::REG_FILM:     sb.film = value;
      scr_pkg::REG_PORE:     sb.pore = value;
      default:               sb.reaction = value;
    endcase
  endtask

  task automatic write_all(logic [30:0] cap, logic [30:0] t1, logic [30:0] t2,
      logic [30:0] t3);
    write_reg(scr_pkg::REG_CAPACITY, cap);
    write_reg(scr_pkg::REG_FILM, t1);
    write_reg(scr_pkg::REG_PORE, t2);
    write_reg(scr_pkg::REG_REACTION, t3);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: reset settings, fraction full, half, depleted, and the field corners
    send_request(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_request(32'h0000_8000, 32'h0000_4000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_request(32'h0001_0000, 1, 32'h0001_0000, 32'h0001_0000, 1);
    send_request(32'h0002_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    repeat (120) send_random();

    // zero capacity: rate forced to zero
    write_all(0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000);
    send_request(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    repeat (100) send_random();

    // denominator zero: all time constants zero
    write_all(31'h0001_0000, 0, 0, 0);
    send_request(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_request(32'h0000_8000, 0, 32'h0001_0000, 32'h0001_0000, 0);
    repeat (100) send_random();

    // largest register values; negative film term
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    repeat (140) send_random();

    // tiny capacity so the fraction saturates; film term negative
    write_all(1, 0, 31'h0003_0000, 31'h0000_0001);
    send_request(32'h8000_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
    repeat (140) send_random();

    for (int phase = 0; phase < 4; phase++) begin
      write_all(31'($urandom_range(0, 31'h0010_0000)), 31'($urandom),
                31'($urandom_range(0, 31'h0004_0000)),
                31'($urandom_range(0, 31'h0004_0000)));
      repeat (100) send_random();
    end

    start = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
